// ===== hdl/assert_macros.svh =====
// assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while reset is high
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// clocked check, also active during reset
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// ===== hdl/glr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glr_pkg
// Shared widths, reset values and types of the glitch merging run length unit.
// ----------------------------------------------------------------------------
`default_nettype none

package glr_pkg;

   localparam int COUNT_WIDTH_DEF   = 16;
   localparam int RUN_LEN_W         = 16;
   localparam int LIMIT_W           = 8;
   localparam int STREAK_W          = 8;
   localparam int BOUND_W           = LIMIT_W + STREAK_W + 1;

   localparam logic [LIMIT_W-1:0] GLITCH_LIMIT_RST = LIMIT_W'(2);

   typedef struct packed {
      logic [RUN_LEN_W-1:0] run_length;
      logic                 run_value;
   } rsp_word_type;

   typedef struct packed {
      logic         emit;
      rsp_word_type word;
   } step_result_type;

endpackage

`default_nettype wire

// ===== hdl/glr_channels.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glr channels
// Valid/ready channel interfaces for sample words and run words.
// ----------------------------------------------------------------------------
`default_nettype none

interface glr_req_if import glr_pkg::*; ();
   logic valid;
   logic ready;
   logic sample_bit;

   modport source (output valid, output sample_bit, input ready);
   modport sink   (input valid, input sample_bit, output ready);
endinterface

interface glr_rsp_if import glr_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [RUN_LEN_W-1:0] run_length;
   logic                 run_value;

   modport source (output valid, output run_length, output run_value, input ready);
   modport sink   (input valid, input run_length, input run_value, output ready);
endinterface

`default_nettype wire

// ===== hdl/glr_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glr_core
// Run counters, merge streak and glitch decision; one sample per step.
// ----------------------------------------------------------------------------
`default_nettype none

module glr_core import glr_pkg::*; #(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               step,
   input  wire logic               sample_bit,
   input  wire logic [LIMIT_W-1:0] glitch_limit,
   output step_result_type         result
);

   localparam int SUM_W = COUNT_WIDTH + 2;
   localparam int CMP_W = (COUNT_WIDTH > BOUND_W) ? COUNT_WIDTH : BOUND_W;
   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
   localparam logic [STREAK_W-1:0]    STREAK_MAX = '1;

   logic [COUNT_WIDTH-1:0] ones_ff, ones_in;
   logic [COUNT_WIDTH-1:0] zeros_ff, zeros_in;
   logic [STREAK_W-1:0]    streak_ff, streak_in;
   logic                   first_done_ff, first_done_in;

   logic [COUNT_WIDTH-1:0] ended;
   logic [COUNT_WIDTH-1:0] grow;
   logic [COUNT_WIDTH-1:0] grow_next;
   logic [BOUND_W-1:0]     bound;
   logic [SUM_W-1:0]       sum;
   logic                   change;
   logic                   glitch;
   logic [RUN_LEN_W-1:0]   len_sat;

   always_comb begin
      ended  = sample_bit ? zeros_ff : ones_ff;
      grow   = sample_bit ? ones_ff : zeros_ff;
      change = (ended != '0);
      bound  = BOUND_W'({{(STREAK_W+1){1'b0}}, glitch_limit} *
                        ({{(LIMIT_W){1'b0}}, 1'b0, streak_ff} + BOUND_W'(1)));
      glitch = (CMP_W'(ended) <= CMP_W'(bound));
      sum    = SUM_W'(grow) + ((change && glitch) ? SUM_W'(ended) : '0) + SUM_W'(1);
      grow_next = (sum > SUM_W'(CNT_MAX)) ? CNT_MAX : sum[COUNT_WIDTH-1:0];
   end

   generate
      if (COUNT_WIDTH > RUN_LEN_W) begin : g_len_sat
         assign len_sat = (|ended[COUNT_WIDTH-1:RUN_LEN_W]) ? '1 : ended[RUN_LEN_W-1:0];
      end else begin : g_len_ext
         assign len_sat = RUN_LEN_W'(ended);
      end
   endgenerate

   always_comb begin
      ones_in       = sample_bit ? grow_next : '0;
      zeros_in      = sample_bit ? '0 : grow_next;
      streak_in     = streak_ff;
      first_done_in = first_done_ff;
      if (change) begin
         if (glitch) begin
            if (streak_ff != STREAK_MAX) begin
               streak_in = streak_ff + STREAK_W'(1);
            end
         end else begin
            streak_in     = '0;
            first_done_in = 1'b1;
         end
      end
   end

   assign result.emit            = change && !glitch && first_done_ff;
   assign result.word.run_length = len_sat;
   assign result.word.run_value  = ~sample_bit;

   always_ff @(posedge clock) begin
      if (reset) begin
         ones_ff       <= '0;
         zeros_ff      <= '0;
         streak_ff     <= '0;
         first_done_ff <= 1'b0;
      end else if (step) begin
         ones_ff       <= ones_in;
         zeros_ff      <= zeros_in;
         streak_ff     <= streak_in;
         first_done_ff <= first_done_in;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/glitch_merging_run_length_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glitch_merging_run_length_unit
// A finished run word is registered; it shows in the cycle after its closing
// sample. Throughput: one sample word per cycle unless the output stalls; the
// run decision is one 8x9 multiply and one compare between state and output registers.
// Reset: counters, streak and output valid clear; glitch_limit returns to 2.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module glitch_merging_run_length_unit import glr_pkg::*; #(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   glr_req_if.sink                 req_chan,
   glr_rsp_if.source               rsp_chan,
   input  wire logic               csr_we,
   input  wire logic [LIMIT_W-1:0] csr_wdata
);

   logic [LIMIT_W-1:0] glitch_limit_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_word_type       rsp_word_ff, rsp_word_in;
   logic               req_accept;
   step_result_type    step_res;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_accept     = req_chan.valid && req_chan.ready;

   glr_core #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .step         (req_accept),
      .sample_bit   (req_chan.sample_bit),
      .glitch_limit (glitch_limit_ff),
      .result       (step_res)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_word_in  = rsp_word_ff;
      if (req_accept && step_res.emit) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = step_res.word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         glitch_limit_ff <= GLITCH_LIMIT_RST;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_we) begin
            glitch_limit_ff <= csr_wdata;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.run_length = rsp_word_ff.run_length;
   assign rsp_chan.run_value  = rsp_word_ff.run_value;

   `ASSERT_CLK(a_emit_shows, (req_accept && step_res.emit) |=> rsp_valid_ff, "emitted word lost")
   `ASSERT_CLK(a_stall_blocks, (rsp_valid_ff && !rsp_chan.ready) |-> !req_chan.ready, "accept while output stalled")
   `ASSERT_CLK(a_len_nonzero, rsp_valid_ff |-> (rsp_word_ff.run_length != '0), "zero run length")

endmodule

`default_nettype wire
